// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Both sample on clk and stay quiet while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// ----- rtl/ctf_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctf_pkg: shared types and constants for the Celsius word converter
// Character codes, scanner states, result kinds and the accumulator limits.
// ----------------------------------------------------------------------------
package ctf_pkg;

	localparam int ACC_BITS = 32;
	localparam longint ACC_MAX = (64'sd1 <<< (ACC_BITS - 1)) - 64'sd1;

	// Accumulator is kept as s = 5*k + r, 0 <= r < 5
	localparam int K_W = ACC_BITS - 1;
	localparam int KX_W = ACC_BITS + 3;
	localparam int FAHR_W = 33;
	localparam int FAHR_PAD = 40;
	localparam int CV_W = (ACC_BITS + 3 > FAHR_W) ? ACC_BITS + 3 : FAHR_W;

	localparam logic signed [K_W-1:0] K_MAX = K_W'(ACC_MAX / 5);
	localparam logic [2:0] R_MAX = 3'(ACC_MAX % 5);
	localparam logic signed [K_W-1:0] K_MIN =
		K_W'(-(ACC_MAX / 5) - (((ACC_MAX % 5) != 0) ? 1 : 0));
	localparam logic [2:0] R_MIN = 3'((((ACC_MAX % 5) != 0) ? 5 - (ACC_MAX % 5) : 0));

	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_VT    = 8'h0B;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_C  = 8'h43;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'd0,
		ST_SKIP  = 3'd1,
		ST_HOLD  = 3'd2,
		ST_PLUS  = 3'd3,
		ST_NEG   = 3'd4,
		ST_POS   = 3'd5,
		ST_MINUS = 3'd6
	} scan_state_t;

	typedef enum logic [1:0] {
		KIND_NL       = 2'd0,
		KIND_TEMP_SP  = 2'd1,
		KIND_TEMP_SNL = 2'd2,
		KIND_TEMP_NL  = 2'd3
	} kind_t;

	typedef struct packed {
		logic [7:0] code;
		logic       last;
	} item_t;

	typedef struct packed {
		logic                     emit;
		kind_t                    kind;
		logic signed [FAHR_W-1:0] value;
		scan_state_t              state;
	} scan_res_t;

	// floor(t/5) for t up to 50
	function automatic logic [3:0] div5_small(input logic [5:0] t);
		logic [3:0] q;
		q = '0;
		for (int i = 1; i <= 10; i++) begin
			if (t >= 6'(5 * i))
				q = q + 4'd1;
		end
		return q;
	endfunction

	// floor((9*r + 162) / 5) for r in 0..4
	function automatic logic [5:0] fahr_ofs(input logic [2:0] r);
		logic [5:0] f;
		case (r)
			3'd0: f = 6'd32;
			3'd1: f = 6'd34;
			3'd2: f = 6'd36;
			3'd3: f = 6'd37;
			3'd4: f = 6'd39;
			default: f = 6'd32;
		endcase
		return f;
	endfunction

endpackage
`default_nettype wire

// ----- rtl/ctf_scan.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ctf_scan: word recognizer and Celsius to Fahrenheit arithmetic
// Holds the scanner state, the digit accumulator (as quotient and remainder
// by five) and the converted value waiting for its terminator.
// ----------------------------------------------------------------------------
module ctf_scan (
	input  wire                clk,
	input  wire                arst_n,
	input  ctf_pkg::item_t     item,
	input  wire                fire,
	output ctf_pkg::scan_res_t res
);

	ctf_pkg::scan_state_t state_q, state_d;
	logic signed [ctf_pkg::K_W-1:0]    k_q;
	logic [2:0]                        r_q;
	logic signed [ctf_pkg::FAHR_W-1:0] pend_q;

	logic is_digit, is_letter, is_blank, is_eol, is_sign;
	logic load_acc, load_pend;
	logic emit;
	ctf_pkg::kind_t kind;

	always_comb begin
		is_digit  = item.code inside {[ctf_pkg::CH_ZERO:ctf_pkg::CH_NINE]};
		is_letter = item.code inside {[8'h41:8'h5A], [8'h61:8'h7A]};
		is_blank  = item.code inside {ctf_pkg::CH_SPACE, ctf_pkg::CH_TAB};
		is_eol    = item.code inside {ctf_pkg::CH_LF, ctf_pkg::CH_VT};
		is_sign   = item.code inside {ctf_pkg::CH_PLUS, ctf_pkg::CH_MINUS};
	end

	// digit arithmetic: s' = 10*s +/- d with s = 5k + r
	logic                            neg, start;
	logic [3:0]                      dig, q5;
	logic [2:0]                      r_base, r_new;
	logic [5:0]                      t, rem;
	logic signed [ctf_pkg::KX_W-1:0] kb, k_ext;
	logic signed [ctf_pkg::K_W-1:0]  k_next;
	logic [2:0]                      r_next;
	logic signed [ctf_pkg::KX_W-1:0] k_max_x, k_min_x;

	assign k_max_x = ctf_pkg::KX_W'(ctf_pkg::K_MAX);
	assign k_min_x = ctf_pkg::KX_W'(ctf_pkg::K_MIN);

	always_comb begin
		neg    = (state_q == ctf_pkg::ST_NEG) || (state_q == ctf_pkg::ST_MINUS);
		start  = !((state_q == ctf_pkg::ST_NEG) || (state_q == ctf_pkg::ST_POS));
		dig    = 4'(item.code - ctf_pkg::CH_ZERO);
		r_base = start ? 3'd0 : r_q;
		kb     = start ? '0 : ctf_pkg::KX_W'(k_q);
		t      = 6'({r_base, 3'b000}) + 6'({r_base, 1'b0})
			+ (neg ? 6'(6'd10 - 6'(dig)) : 6'(dig));
		q5     = ctf_pkg::div5_small(t);
		rem    = t - 6'({q5, 2'b00}) - 6'(q5);
		r_new  = rem[2:0];
		k_ext  = (kb <<< 3) + (kb <<< 1) + ctf_pkg::KX_W'(q5)
			- (neg ? ctf_pkg::KX_W'(2) : '0);
		k_next = ctf_pkg::K_W'(k_ext);
		r_next = r_new;
		if (!neg && ((k_ext > k_max_x) || ((k_ext == k_max_x) && (r_new > ctf_pkg::R_MAX)))) begin
			k_next = ctf_pkg::K_MAX;
			r_next = ctf_pkg::R_MAX;
		end else if (neg && ((k_ext < k_min_x)
				|| ((k_ext == k_min_x) && (r_new < ctf_pkg::R_MIN)))) begin
			k_next = ctf_pkg::K_MIN;
			r_next = ctf_pkg::R_MIN;
		end
	end

	// round(9s/5 + 32) = 9k + floor((9r + 162) / 5)
	logic signed [ctf_pkg::CV_W-1:0] kc, conv;

	always_comb begin
		kc   = ctf_pkg::CV_W'(k_q);
		conv = (kc <<< 3) + kc + ctf_pkg::CV_W'(ctf_pkg::fahr_ofs(r_q));
	end

	// next state
	always_comb begin
		state_d   = state_q;
		load_acc  = 1'b0;
		load_pend = 1'b0;
		if (item.last) begin
			state_d = ctf_pkg::ST_IDLE;
		end else begin
			case (state_q)
				ctf_pkg::ST_SKIP: begin
					if (item.code == ctf_pkg::CH_SPACE || is_eol)
						state_d = ctf_pkg::ST_IDLE;
				end
				ctf_pkg::ST_HOLD: begin
					if (is_blank || is_eol)
						state_d = ctf_pkg::ST_IDLE;
					else
						state_d = ctf_pkg::ST_SKIP;
				end
				ctf_pkg::ST_NEG, ctf_pkg::ST_POS: begin
					if (is_digit)
						load_acc = 1'b1;
					else if (item.code == ctf_pkg::CH_UC_C) begin
						load_pend = 1'b1;
						state_d   = ctf_pkg::ST_HOLD;
					end else if (item.code == ctf_pkg::CH_SPACE || is_eol)
						state_d = ctf_pkg::ST_IDLE;
					else
						state_d = ctf_pkg::ST_SKIP;
				end
				ctf_pkg::ST_PLUS, ctf_pkg::ST_MINUS: begin
					if (is_blank || is_eol)
						state_d = ctf_pkg::ST_IDLE;
					else if (is_letter || is_sign)
						state_d = ctf_pkg::ST_SKIP;
					else if (is_digit) begin
						load_acc = 1'b1;
						state_d  = (state_q == ctf_pkg::ST_MINUS) ? ctf_pkg::ST_NEG
							: ctf_pkg::ST_POS;
					end
				end
				default: begin
					// idle, and the unused code behaves the same
					if (is_blank || is_eol)
						state_d = ctf_pkg::ST_IDLE;
					else if (is_letter)
						state_d = ctf_pkg::ST_SKIP;
					else if (is_digit) begin
						load_acc = 1'b1;
						state_d  = ctf_pkg::ST_POS;
					end else if (item.code == ctf_pkg::CH_MINUS)
						state_d = ctf_pkg::ST_MINUS;
					else if (item.code == ctf_pkg::CH_PLUS)
						state_d = ctf_pkg::ST_PLUS;
					else
						state_d = ctf_pkg::ST_IDLE;
				end
			endcase
		end
	end

	// outputs
	always_comb begin
		emit = 1'b0;
		kind = ctf_pkg::KIND_NL;
		if (item.last) begin
			emit = 1'b1;
			kind = (state_q == ctf_pkg::ST_HOLD) ? ctf_pkg::KIND_TEMP_NL : ctf_pkg::KIND_NL;
		end else begin
			case (state_q)
				ctf_pkg::ST_HOLD: begin
					if (is_blank) begin
						emit = 1'b1;
						kind = ctf_pkg::KIND_TEMP_SP;
					end else if (is_eol) begin
						emit = 1'b1;
						kind = ctf_pkg::KIND_TEMP_SNL;
					end
				end
				default: begin
					emit = is_eol;
					kind = ctf_pkg::KIND_NL;
				end
			endcase
		end
	end

	assign res.emit  = emit;
	assign res.kind  = kind;
	assign res.value = (kind == ctf_pkg::KIND_NL) ? '0 : pend_q;
	assign res.state = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ctf_pkg::ST_IDLE;
		else if (fire)
			state_q <= state_d;
	end

	always_ff @(posedge clk) begin
		if (fire && load_acc) begin
			k_q <= k_next;
			r_q <= r_next;
		end
		if (fire && load_pend)
			pend_q <= conv[ctf_pkg::FAHR_W-1:0];
	end

endmodule
`default_nettype wire

// ----- rtl/celsius_token_to_fahrenheit.sv -----
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// celsius_token_to_fahrenheit: text stream Celsius word converter
// Scans a byte stream for signed decimal words ending in 'C' and returns each
// as a rounded Fahrenheit value, plus newline markers.
// ----------------------------------------------------------------------------
// One byte is taken per clock cycle with the result side ready. A byte sits
// in the input register while the recognizer and the digit arithmetic
// update the scanner state, then any result lands in the output register.
// The scanner state register and the accumulator registers are the loops.
// Bytes with no result never wait on the master side; a byte that makes a
// result waits in the input register until the output register is free.
// tlast on the input marks end of stream and always yields a result.
// ----------------------------------------------------------------------------
module celsius_token_to_fahrenheit (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        s_axis_tvalid,
	output logic       s_axis_tready,
	input  wire  [7:0] s_axis_tdata,   // [7:0] byte_req
	input  wire        s_axis_tlast,   // end_of_input
	output logic       m_axis_tvalid,
	input  wire        m_axis_tready,
	output logic [39:0] m_axis_tdata,  // [32:0] fahrenheit, [39:33] zero
	output logic [1:0] m_axis_tuser    // [1:0] kind
);

	logic                valid_s1;
	ctf_pkg::item_t      item_s1;
	ctf_pkg::scan_res_t  res;
	logic                out_free, fire;

	logic                              m_valid_q;
	ctf_pkg::kind_t                    m_kind_q;
	logic signed [ctf_pkg::FAHR_W-1:0] m_value_q;

	ctf_scan u_scan (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item_s1),
		.fire   (fire),
		.res    (res)
	);

	assign out_free      = !m_valid_q || m_axis_tready;
	assign fire          = valid_s1 && (!res.emit || out_free);
	assign s_axis_tready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (s_axis_tready)
				valid_s1 <= s_axis_tvalid;
			if (fire && res.emit)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			item_s1.code <= s_axis_tdata;
			item_s1.last <= s_axis_tlast;
		end
		if (fire && res.emit) begin
			m_kind_q  <= res.kind;
			m_value_q <= res.value;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tuser  = m_kind_q;
	assign m_axis_tdata  = {(ctf_pkg::FAHR_PAD - ctf_pkg::FAHR_W)'(0), m_value_q};

	`ASSERT_SAME(a_nl_zero, m_valid_q && (m_kind_q == ctf_pkg::KIND_NL), m_value_q == '0)
	`ASSERT_NEXT(a_eoi_idle, fire && item_s1.last, res.state == ctf_pkg::ST_IDLE)
	`ASSERT_NEXT(a_stall_hold, valid_s1 && !fire, $stable(res.state))
	`ASSERT_NEXT(a_result_out, fire && res.emit, m_valid_q)

endmodule
`default_nettype wire

// ----- test/celsius_token_to_fahrenheit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// celsius_token_to_fahrenheit_tb: self-checking bench for the Celsius word scanner
// Feeds a short table of directed bytes and then random text made mostly of
// optionally signed "<digits>C" words plus noise, with random idling on both streams.
// Every byte transaction runs through a local scanner model whose results are
// queued and compared field by field against the master-side output.
// ----------------------------------------------------------------------------
module celsius_token_to_fahrenheit_tb;

	import ctf_pkg::*;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 16;
	localparam int DIR_ROWS     = 25;
	localparam int RAND_ITEMS   = 450;
	localparam int CALM_TAIL    = 60;

	localparam logic [7:0] CH_UC_A = 8'h41;
	localparam logic [7:0] CH_UC_Z = 8'h5A;
	localparam logic [7:0] CH_LC_A = 8'h61;
	localparam logic [7:0] CH_LC_Z = 8'h7A;

	typedef struct {
		kind_t                    kind;
		logic signed [FAHR_W-1:0] fahr;
	} temp_res_t;

	typedef struct {
		logic [7:0] code;
		logic       last;
		bit         fixed;
		kind_t      kind;
		longint     fahr;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	wire         s_axis_tready;
	logic [7:0]  s_axis_tdata = '0;
	logic        s_axis_tlast = 1'b0;
	wire         m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	wire  [39:0] m_axis_tdata;
	wire  [1:0]  m_axis_tuser;

	// scanner model state
	scan_state_t scan_q = ST_IDLE;
	longint      acc_q = 0;
	longint      pend_q = 0;

	temp_res_t   pending_temps [$];
	temp_res_t   want;
	int          err_count = 0;
	int          n_sent = 0;
	int          cycle_count = 0;
	int          stall_left = 0;
	bit          idle_en = 1'b1;

	// fixed expectations only where they are obvious; rows with the fixed bit clear use the model
	dir_row_t dir_rows [DIR_ROWS] = '{
		'{CH_LF,    1'b0, 1'b1, KIND_NL,       0},
		'{CH_ZERO,  1'b0, 1'b0, KIND_NL,       0},
		'{CH_UC_C,  1'b0, 1'b0, KIND_NL,       0},
		'{CH_SPACE, 1'b0, 1'b1, KIND_TEMP_SP,  32},
		'{CH_MINUS, 1'b0, 1'b0, KIND_NL,       0},
		'{8'h34,    1'b0, 1'b0, KIND_NL,       0},
		'{CH_ZERO,  1'b0, 1'b0, KIND_NL,       0},
		'{CH_UC_C,  1'b0, 1'b0, KIND_NL,       0},
		'{CH_LF,    1'b0, 1'b1, KIND_TEMP_SNL, -40},
		'{8'h31,    1'b0, 1'b0, KIND_NL,       0},
		'{CH_ZERO,  1'b0, 1'b0, KIND_NL,       0},
		'{CH_ZERO,  1'b0, 1'b0, KIND_NL,       0},
		'{CH_UC_C,  1'b0, 1'b0, KIND_NL,       0},
		'{8'h00,    1'b1, 1'b1, KIND_TEMP_NL,  212},
		'{CH_PLUS,  1'b0, 1'b0, KIND_NL,       0},
		'{8'h37,    1'b0, 1'b0, KIND_NL,       0},
		'{CH_UC_C,  1'b0, 1'b0, KIND_NL,       0},
		'{8'h78,    1'b0, 1'b0, KIND_NL,       0},
		'{CH_TAB,   1'b0, 1'b0, KIND_NL,       0},
		'{CH_VT,    1'b0, 1'b1, KIND_NL,       0},
		'{8'h23,    1'b0, 1'b0, KIND_NL,       0},
		'{CH_MINUS, 1'b0, 1'b0, KIND_NL,       0},
		'{8'h25,    1'b0, 1'b0, KIND_NL,       0},
		'{CH_NINE,  1'b0, 1'b0, KIND_NL,       0},
		'{8'hFF,    1'b1, 1'b1, KIND_NL,       0}
	};

	celsius_token_to_fahrenheit DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// round(9c/5 + 32) with floor division, exact in integers
	function automatic longint celsius_to_fahr(input longint c);
		longint n, q;
		n = 9 * c + 162;
		q = n / 5;
		if (n % 5 < 0)
			q = q - 1;
		return q;
	endfunction

	task automatic clear_scan(input scan_state_t nxt);
		scan_q = nxt;
		acc_q = 0;
		pend_q = 0;
	endtask

	task automatic scan_char(input logic [7:0] c, input logic eoi, output bit got,
			output temp_res_t r);
		bit blank, eol, digit, letter, sign;
		longint d;
		got = 1'b0;
		r.kind = KIND_NL;
		r.fahr = '0;
		blank = (c == CH_SPACE) || (c == CH_TAB);
		eol = (c == CH_LF) || (c == CH_VT);
		digit = (c >= CH_ZERO) && (c <= CH_NINE);
		letter = (c >= CH_UC_A && c <= CH_UC_Z) || (c >= CH_LC_A && c <= CH_LC_Z);
		sign = (c == CH_PLUS) || (c == CH_MINUS);
		d = longint'(c - CH_ZERO);
		if (eoi) begin
			got = 1'b1;
			if (scan_q == ST_HOLD) begin
				r.kind = KIND_TEMP_NL;
				r.fahr = FAHR_W'(pend_q);
			end
			clear_scan(ST_IDLE);
		end else begin
			case (scan_q)
				ST_SKIP: begin
					// tab does not end a skipped word
					if (c == CH_SPACE) begin
						clear_scan(ST_IDLE);
					end else if (eol) begin
						clear_scan(ST_IDLE);
						got = 1'b1;
					end
				end
				ST_HOLD: begin
					if (blank || eol) begin
						got = 1'b1;
						r.kind = blank ? KIND_TEMP_SP : KIND_TEMP_SNL;
						r.fahr = FAHR_W'(pend_q);
						clear_scan(ST_IDLE);
					end else begin
						clear_scan(ST_SKIP);
					end
				end
				ST_NEG, ST_POS: begin
					if (digit) begin
						if (scan_q == ST_POS) begin
							acc_q = acc_q * 10 + d;
							if (acc_q > ACC_MAX)
								acc_q = ACC_MAX;
						end else begin
							acc_q = acc_q * 10 - d;
							if (acc_q < -ACC_MAX)
								acc_q = -ACC_MAX;
						end
					end else if (c == CH_UC_C) begin
						pend_q = celsius_to_fahr(acc_q);
						acc_q = 0;
						scan_q = ST_HOLD;
					end else if (c == CH_SPACE) begin
						clear_scan(ST_IDLE);
					end else if (eol) begin
						clear_scan(ST_IDLE);
						got = 1'b1;
					end else begin
						clear_scan(ST_SKIP);
					end
				end
				ST_PLUS, ST_MINUS: begin
					if (blank) begin
						clear_scan(ST_IDLE);
					end else if (eol) begin
						clear_scan(ST_IDLE);
						got = 1'b1;
					end else if (letter || sign) begin
						clear_scan(ST_SKIP);
					end else if (digit) begin
						acc_q = (scan_q == ST_MINUS) ? -d : d;
						scan_q = (scan_q == ST_MINUS) ? ST_NEG : ST_POS;
					end
				end
				default: begin
					if (blank) begin
						clear_scan(ST_IDLE);
					end else if (eol) begin
						clear_scan(ST_IDLE);
						got = 1'b1;
					end else if (letter) begin
						clear_scan(ST_SKIP);
					end else if (digit) begin
						acc_q = d;
						scan_q = ST_POS;
					end else if (c == CH_MINUS) begin
						scan_q = ST_MINUS;
					end else if (c == CH_PLUS) begin
						scan_q = ST_PLUS;
					end
				end
			endcase
		end
	endtask

	task automatic send_item(input logic [7:0] code, input logic last, input bit fixed,
			input kind_t fkind, input longint ffahr);
		bit got;
		temp_res_t r;
		if (idle_en && $urandom_range(0, 5) == 0) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= code;
		s_axis_tlast <= last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		scan_char(code, last, got, r);
		if (fixed) begin
			got = 1'b1;
			r.kind = fkind;
			r.fahr = FAHR_W'(ffahr);
		end
		if (got)
			pending_temps.push_back(r);
		n_sent++;
	endtask

	task automatic report_mismatch(input string msg);
		$display("%0t mismatch: %s", $time, msg);
		err_count++;
	endtask

	function automatic logic [7:0] rand_letter();
		return $urandom_range(0, 1) ? 8'($urandom_range(CH_UC_A, CH_UC_Z))
			: 8'($urandom_range(CH_LC_A, CH_LC_Z));
	endfunction

	// master-side backpressure in bursts
	always @(posedge clk) begin
		if (idle_en && stall_left == 0 && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 12);
			m_axis_tready <= 1'b0;
		end else if (stall_left > 1) begin
			stall_left <= stall_left - 1;
			m_axis_tready <= 1'b0;
		end else begin
			stall_left <= 0;
			m_axis_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (pending_temps.size() == 0) begin
				report_mismatch("result transaction with nothing expected");
			end else begin
				want = pending_temps.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch($sformatf("kind %0d, expected %0d",
						m_axis_tuser, want.kind));
				if ($signed(m_axis_tdata[FAHR_W-1:0]) !== want.fahr)
					report_mismatch($sformatf("fahrenheit %0d, expected %0d",
						$signed(m_axis_tdata[FAHR_W-1:0]), want.fahr));
				if (m_axis_tdata[39:FAHR_W] !== '0)
					report_mismatch($sformatf("tdata pad bits %0h", m_axis_tdata[39:FAHR_W]));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[celsius_token_to_fahrenheit] ERROR");
			$finish;
		end
	end

	initial begin : stimulus
		int pick, ndig, term, nbytes;
		logic [7:0] ch;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < DIR_ROWS; i++)
			send_item(dir_rows[i].code, dir_rows[i].last, dir_rows[i].fixed,
				dir_rows[i].kind, dir_rows[i].fahr);

		while (n_sent < DIR_ROWS + RAND_ITEMS) begin
			if (n_sent >= DIR_ROWS + RAND_ITEMS - CALM_TAIL)
				idle_en = 1'b0;
			else if ($urandom_range(0, 7) == 0)
				idle_en = $urandom_range(0, 2) != 0;
			pick = $urandom_range(0, 9);
			if (pick <= 6) begin
				// well-formed word with random content and terminator
				term = $urandom_range(0, 2);
				if (term == 1)
					send_item(CH_MINUS, 1'b0, 1'b0, KIND_NL, 0);
				else if (term == 2)
					send_item(CH_PLUS, 1'b0, 1'b0, KIND_NL, 0);
				ndig = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12)
					: $urandom_range(1, 4);
				for (int k = 0; k < ndig; k++)
					send_item(8'(CH_ZERO + $urandom_range(0, 9)), 1'b0, 1'b0, KIND_NL, 0);
				send_item(CH_UC_C, 1'b0, 1'b0, KIND_NL, 0);
				term = $urandom_range(0, 9);
				case (term)
					0, 1, 2: ch = CH_SPACE;
					3:       ch = CH_TAB;
					4:       ch = CH_LF;
					5:       ch = CH_VT;
					7:       ch = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
					8:       ch = 8'($urandom_range(0, 255));
					default: ch = rand_letter();
				endcase
				send_item(ch, term == 6, 1'b0, KIND_NL, 0);
				if (term >= 7)
					send_item($urandom_range(0, 1) ? CH_SPACE : CH_LF, 1'b0, 1'b0, KIND_NL, 0);
			end else begin
				nbytes = $urandom_range(1, 6);
				for (int k = 0; k < nbytes; k++) begin
					case ($urandom_range(0, 7))
						0: ch = 8'($urandom_range(0, 255));
						1: ch = rand_letter();
						2: ch = CH_TAB;
						3: ch = 8'(CH_ZERO + $urandom_range(0, 9));
						4: ch = $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
						5: ch = CH_SPACE;
						6: ch = $urandom_range(0, 1) ? CH_LF : CH_VT;
						default: ch = 8'($urandom_range(8'h21, 8'h2F));
					endcase
					send_item(ch, $urandom_range(0, 14) == 0, 1'b0, KIND_NL, 0);
				end
			end
		end

		s_axis_tvalid <= 1'b0;
		while (pending_temps.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("[celsius_token_to_fahrenheit] OK");
		else
			$display("[celsius_token_to_fahrenheit] ERROR");
		$finish;
	end

endmodule
